// ===== hw/rtl/dfpc_pkg.sv =====
// Shared constants, types and register codes of the depth-to-point-cloud block.
`default_nettype none
package dfpc_pkg;

    // field widths
    localparam int CODE_W  = 11;   // raw depth code / table index
    localparam int Z_W     = 16;   // unsigned Q4.12 meters
    localparam int PT_W    = 18;   // signed Q5.12 meters
    localparam int COUNT_W = 10;   // column and row counters
    localparam int D_W     = 16;   // signed difference in 1/16 pixel
    localparam int MAG_W   = 15;   // magnitude of a difference
    localparam int INV_W   = 24;   // reciprocal focal length, 2^-24 units
    localparam int FW_W    = 11;
    localparam int STEP_W  = 5;
    localparam int OFF_W   = 7;
    localparam int C_W     = 14;

    // stream and config port widths
    localparam int S_TDATA_W  = 32;  // raw_depth, table_value, zero fill
    localparam int S_TUSER_W  = 2;   // command, first_of_frame
    localparam int M_TDATA_W  = 2 * PT_W + Z_W + 2 * COUNT_W;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    // table size default, row width cap
    localparam int DEPTH_CODES_DEF = 2048;
    localparam int MAX_WIDTH       = 1024;
    localparam int COUNTER_LIMIT   = 1 << COUNT_W;
    localparam int WIDTH_LIMIT_I   = (MAX_WIDTH < COUNTER_LIMIT) ? MAX_WIDTH : COUNTER_LIMIT;
    localparam logic [FW_W-1:0] WIDTH_LIMIT = FW_W'(WIDTH_LIMIT_I);

    // result queue
    localparam int OUT_DEPTH = 8;

    // rounding of the 28 fraction bits dropped from the product
    localparam int PROD_W  = MAG_W + Z_W + INV_W;
    localparam int SHIFT   = 28;
    localparam int Q_W     = PROD_W + 1 - SHIFT;
    localparam logic [Q_W-1:0] Q_MAX     = Q_W'(131071);
    localparam logic [Q_W-1:0] Q_MIN_MAG = Q_W'(131072);

    // register reset values
    localparam logic [FW_W-1:0]   FRAME_WIDTH_RST   = 11'd640;
    localparam logic [STEP_W-1:0] MESH_STEP_RST     = 5'd1;
    localparam logic [OFF_W-1:0]  COLUMN_OFFSET_RST = 7'h79;   // -7
    localparam logic [C_W-1:0]    CENTER_X_RST      = 14'd5120;
    localparam logic [C_W-1:0]    CENTER_Y_RST      = 14'd3840;
    localparam logic [INV_W-1:0]  INV_FOCAL_X_RST   = 24'd28926;
    localparam logic [INV_W-1:0]  INV_FOCAL_Y_RST   = 24'd28926;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MESH_STEP     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COLUMN_OFFSET = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Y      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_FOCAL_X   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_FOCAL_Y   = 3'd6;

    // status of the remainder unit
    typedef struct packed {
        logic busy;
        logic done;
    } mod_status_t;

endpackage
`default_nettype wire

// ===== hw/rtl/dfpc_ram.sv =====
// Generic simple dual-port RAM with registered read.
`default_nettype none
module dfpc_ram #(
    parameter int DATA_W = 16,
    parameter int DEPTH  = 2048
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [DATA_W-1:0]        wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [DATA_W-1:0]        rdata
);

    logic [DATA_W-1:0] mem_reg [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem_reg[raddr];
        end
    end

endmodule
`default_nettype wire

// ===== hw/rtl/dfpc_mod_unit.sv =====
// Bit-serial remainder unit: dividend mod divisor, one dividend bit per cycle.
`default_nettype none
module dfpc_mod_unit #(
    parameter int DVD_W = 10,
    parameter int DIV_W = 5
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               start,
    input  wire logic [DVD_W-1:0]   dividend,
    input  wire logic [DIV_W-1:0]   divisor,
    output dfpc_pkg::mod_status_t   status,
    output logic      [DIV_W-1:0]   remainder
);

    localparam int CNT_W = (DVD_W > 1) ? $clog2(DVD_W) : 1;
    localparam logic [CNT_W-1:0] LAST = CNT_W'(DVD_W - 1);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [DVD_W-1:0] dvd_reg, dvd_next;
    logic [DIV_W-1:0] rem_reg, rem_next;
    logic [DIV_W-1:0] div_reg, div_next;
    logic [DIV_W:0]   trial;

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;
        trial     = {rem_reg, dvd_reg[DVD_W-1]};
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            dvd_next  = dividend;
            rem_next  = '0;
            div_next  = divisor;
        end else if (busy_reg) begin
            // rem stays below the divisor, so the restored value fits DIV_W bits
            if (trial >= {1'b0, div_reg}) begin
                rem_next = DIV_W'(trial - {1'b0, div_reg});
            end else begin
                rem_next = DIV_W'(trial);
            end
            dvd_next = dvd_reg << 1;
            cnt_next = cnt_reg + CNT_W'(1);
            if (cnt_reg == LAST) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        cnt_reg <= cnt_next;
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
        div_reg <= div_next;
    end

    assign status.busy = busy_reg;
    assign status.done = done_reg;
    assign remainder   = rem_reg;

endmodule
`default_nettype wire

// ===== hw/rtl/dfpc_proj.sv =====
// One projection axis: |d| * z, times 1/f, round, sign and saturate.
`default_nettype none
module dfpc_proj (
    input  wire logic                             aclk,
    input  wire logic signed [dfpc_pkg::D_W-1:0]  d,
    input  wire logic        [dfpc_pkg::Z_W-1:0]  z,
    input  wire logic        [dfpc_pkg::INV_W-1:0] inv,
    output logic signed      [dfpc_pkg::PT_W-1:0] result
);

    localparam int M1_W = dfpc_pkg::MAG_W + dfpc_pkg::Z_W;
    localparam int P_W  = dfpc_pkg::PROD_W;
    localparam int Q_W  = dfpc_pkg::Q_W;

    logic [dfpc_pkg::MAG_W-1:0] mag;
    logic [M1_W-1:0]            m1_reg, m1_next;
    logic                       neg1_reg, neg2_reg;
    logic [P_W-1:0]             prod_reg, prod_next;
    logic [P_W:0]               rounded;
    logic [Q_W-1:0]             q, q_sat;

    assign mag       = d[dfpc_pkg::D_W-1] ? dfpc_pkg::MAG_W'(-d) : dfpc_pkg::MAG_W'(d);
    assign m1_next   = M1_W'(mag) * M1_W'(z);
    assign prod_next = P_W'(m1_reg) * P_W'(inv);

    always_ff @(posedge aclk) begin
        m1_reg   <= m1_next;
        neg1_reg <= d[dfpc_pkg::D_W-1];
        prod_reg <= prod_next;
        neg2_reg <= neg1_reg;
    end

    // round half away from zero on the magnitude
    assign rounded = (P_W + 1)'(prod_reg) + (P_W + 1)'(64'd1 << (dfpc_pkg::SHIFT - 1));
    assign q       = rounded[P_W:dfpc_pkg::SHIFT];

    always_comb begin
        if (neg2_reg) begin
            q_sat  = (q > dfpc_pkg::Q_MIN_MAG) ? dfpc_pkg::Q_MIN_MAG : q;
            result = $signed(dfpc_pkg::PT_W'(-q_sat));
        end else begin
            q_sat  = (q > dfpc_pkg::Q_MAX) ? dfpc_pkg::Q_MAX : q;
            result = $signed(dfpc_pkg::PT_W'(q_sat));
        end
    end

endmodule
`default_nettype wire

// ===== hw/rtl/dfpc_out_fifo.sv =====
// Result queue in front of the master port; also the output register.
`default_nettype none
module dfpc_out_fifo #(
    parameter int WIDTH = 72,
    parameter int DEPTH = 8
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         push,
    input  wire logic [WIDTH-1:0]             push_data,
    input  wire logic                         pop,
    output logic      [WIDTH-1:0]             head,
    output logic      [$clog2(DEPTH+1)-1:0]   count
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_pop;

    assign do_pop = pop && (count_reg != '0);

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !do_pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (!push && do_pop) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign head  = slot_reg[rd_ptr_reg];
    assign count = count_reg;

endmodule
`default_nettype wire

// ===== hw/rtl/depth_frame_to_point_cloud.sv =====
// A mesh-grid pixel passes the table read, difference and product registers to the queue.
// Throughput: one item per cycle; s_tready drops when queued plus in-flight points fill
// the 8-entry result queue, and after a mesh_step write while the serial remainder units
// rebuild the phases. Table writes go to the depth RAM write port; later pixels read them.
// Reset (aresetn low, synchronous): counters zero, registers to defaults, queue empty;
// the depth table keeps its contents and needs no clearing pass.
`default_nettype none
module depth_frame_to_point_cloud #(
    parameter int DEPTH_CODES = dfpc_pkg::DEPTH_CODES_DEF
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    // input pixels and table writes
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    input  wire logic [dfpc_pkg::S_TDATA_W-1:0]   s_tdata,  // raw_depth, table_value
    input  wire logic [dfpc_pkg::S_TUSER_W-1:0]   s_tuser,  // command, first_of_frame
    // output points
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    // point_x, point_y, point_z, pixel_column, pixel_row
    output logic      [dfpc_pkg::M_TDATA_W-1:0]   m_tdata,
    // register writes
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [dfpc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [dfpc_pkg::CFG_DATA_W-1:0]  cfg_data
);

    localparam int ADDR_W   = (DEPTH_CODES > 1) ? $clog2(DEPTH_CODES) : 1;
    localparam int CODE_W   = dfpc_pkg::CODE_W;
    localparam int Z_W      = dfpc_pkg::Z_W;
    localparam int COUNT_W  = dfpc_pkg::COUNT_W;
    localparam int FW_W     = dfpc_pkg::FW_W;
    localparam int STEP_W   = dfpc_pkg::STEP_W;
    localparam int D_W      = dfpc_pkg::D_W;
    localparam int PT_W     = dfpc_pkg::PT_W;
    localparam int QCNT_W   = $clog2(dfpc_pkg::OUT_DEPTH + 1);
    localparam int OCC_W    = $clog2(dfpc_pkg::OUT_DEPTH + 4);
    localparam int SUM_W    = COUNT_W + 2;

    // configuration registers
    logic        [FW_W-1:0]            fw_reg;
    logic        [STEP_W-1:0]          step_reg;
    logic signed [dfpc_pkg::OFF_W-1:0] off_reg;
    logic        [dfpc_pkg::C_W-1:0]   cx_reg, cy_reg;
    logic        [dfpc_pkg::INV_W-1:0] ifx_reg, ify_reg;
    logic                              step_start_reg;
    logic                              cfg_acc;

    // input beat
    logic                 s_acc, pixel_acc, first, cmd;
    logic [CODE_W-1:0]    code;
    logic [Z_W-1:0]       tval;
    logic                 oob;

    // raster counters and their phase modulo mesh_step
    logic [COUNT_W-1:0]   col_reg, col_next, row_reg, row_next;
    logic [STEP_W-1:0]    cph_reg, cph_next, rph_reg, rph_next;
    logic [COUNT_W-1:0]   col_cur, row_cur;
    logic [STEP_W-1:0]    cph_cur, rph_cur, cph_inc, rph_inc;
    logic [STEP_W-1:0]    step_eff;
    logic [FW_W-1:0]      w_eff, col_inc;
    logic                 on_grid, wrap;

    // remainder units
    dfpc_pkg::mod_status_t col_st, row_st;
    logic [STEP_W-1:0]     col_rem, row_rem;
    logic                  hold_in;

    // pipeline
    logic                  e1_reg, e2_reg, e3_reg;
    logic signed [D_W-1:0] dx_next, dy_next, dx1_reg, dy1_reg;
    logic signed [SUM_W-1:0] col_sum;
    logic                  oob1_reg;
    logic [COUNT_W-1:0]    col1_reg, col2_reg, col3_reg, row1_reg, row2_reg, row3_reg;
    logic [Z_W-1:0]        z_s1, z2_reg, z3_reg;
    logic [Z_W-1:0]        ram_rdata;
    logic signed [PT_W-1:0] x_pt, y_pt;

    // result queue
    logic [QCNT_W-1:0]     q_count;
    logic [OCC_W-1:0]      occ;

    assign cmd   = s_tuser[0];
    assign first = s_tuser[1];
    assign code  = s_tdata[CODE_W-1:0];
    assign tval  = s_tdata[CODE_W +: Z_W];
    assign oob   = 32'(code) >= 32'(DEPTH_CODES);

    assign cfg_ready = 1'b1;
    assign cfg_acc   = cfg_valid && cfg_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fw_reg         <= dfpc_pkg::FRAME_WIDTH_RST;
            step_reg       <= dfpc_pkg::MESH_STEP_RST;
            off_reg        <= dfpc_pkg::COLUMN_OFFSET_RST;
            cx_reg         <= dfpc_pkg::CENTER_X_RST;
            cy_reg         <= dfpc_pkg::CENTER_Y_RST;
            ifx_reg        <= dfpc_pkg::INV_FOCAL_X_RST;
            ify_reg        <= dfpc_pkg::INV_FOCAL_Y_RST;
            step_start_reg <= 1'b0;
        end else begin
            step_start_reg <= cfg_acc && (cfg_index == dfpc_pkg::CFG_MESH_STEP);
            if (cfg_acc) begin
                unique case (cfg_index)
                    dfpc_pkg::CFG_FRAME_WIDTH:   fw_reg   <= cfg_data[FW_W-1:0];
                    dfpc_pkg::CFG_MESH_STEP:     step_reg <= cfg_data[STEP_W-1:0];
                    dfpc_pkg::CFG_COLUMN_OFFSET: off_reg  <= $signed(cfg_data[dfpc_pkg::OFF_W-1:0]);
                    dfpc_pkg::CFG_CENTER_X:      cx_reg   <= cfg_data[dfpc_pkg::C_W-1:0];
                    dfpc_pkg::CFG_CENTER_Y:      cy_reg   <= cfg_data[dfpc_pkg::C_W-1:0];
                    dfpc_pkg::CFG_INV_FOCAL_X:   ifx_reg  <= cfg_data[dfpc_pkg::INV_W-1:0];
                    dfpc_pkg::CFG_INV_FOCAL_Y:   ify_reg  <= cfg_data[dfpc_pkg::INV_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    // phases are rebuilt after a step change; hold input until they land
    assign hold_in = step_start_reg || col_st.busy || col_st.done
                     || row_st.busy || row_st.done;

    assign occ = OCC_W'(q_count) + OCC_W'(e1_reg) + OCC_W'(e2_reg) + OCC_W'(e3_reg);
    assign s_tready  = !hold_in && (occ < OCC_W'(dfpc_pkg::OUT_DEPTH));
    assign s_acc     = s_tvalid && s_tready;
    assign pixel_acc = s_acc && !cmd;

    assign step_eff = (step_reg == '0) ? STEP_W'(1) : step_reg;

    always_comb begin
        if (fw_reg == '0) begin
            w_eff = FW_W'(1);
        end else if (fw_reg > dfpc_pkg::WIDTH_LIMIT) begin
            w_eff = dfpc_pkg::WIDTH_LIMIT;
        end else begin
            w_eff = fw_reg;
        end
    end

    always_comb begin
        col_cur = first ? '0 : col_reg;
        row_cur = first ? '0 : row_reg;
        cph_cur = first ? '0 : cph_reg;
        rph_cur = first ? '0 : rph_reg;
        on_grid = (cph_cur == '0) && (rph_cur == '0);
        col_inc = FW_W'(col_cur) + FW_W'(1);
        wrap    = col_inc >= w_eff;
        cph_inc = cph_cur + STEP_W'(1);
        rph_inc = rph_cur + STEP_W'(1);
        if (wrap) begin
            col_next = '0;
            cph_next = '0;
            row_next = row_cur + COUNT_W'(1);
            // the row wraps at the counter limit, which restarts its phase too
            if (row_cur == '1 || rph_inc == step_eff) begin
                rph_next = '0;
            end else begin
                rph_next = rph_inc;
            end
        end else begin
            col_next = col_inc[COUNT_W-1:0];
            cph_next = (cph_inc == step_eff) ? '0 : cph_inc;
            row_next = row_cur;
            rph_next = rph_cur;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
            cph_reg <= '0;
            rph_reg <= '0;
        end else if (pixel_acc) begin
            col_reg <= col_next;
            row_reg <= row_next;
            cph_reg <= cph_next;
            rph_reg <= rph_next;
        end else begin
            if (col_st.done) begin
                cph_reg <= col_rem;
            end
            if (row_st.done) begin
                rph_reg <= row_rem;
            end
        end
    end

    dfpc_mod_unit #(
        .DVD_W (COUNT_W),
        .DIV_W (STEP_W)
    ) u_col_mod (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (step_start_reg),
        .dividend  (col_reg),
        .divisor   (step_eff),
        .status    (col_st),
        .remainder (col_rem)
    );

    dfpc_mod_unit #(
        .DVD_W (COUNT_W),
        .DIV_W (STEP_W)
    ) u_row_mod (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (step_start_reg),
        .dividend  (row_reg),
        .divisor   (step_eff),
        .status    (row_st),
        .remainder (row_rem)
    );

    // a write lands at its edge, so a pixel in the next beat already reads it
    dfpc_ram #(
        .DATA_W (Z_W),
        .DEPTH  (DEPTH_CODES)
    ) u_table (
        .aclk  (aclk),
        .we    (s_acc && cmd && !oob),
        .waddr (ADDR_W'(code)),
        .wdata (tval),
        .re    (pixel_acc && on_grid),
        .raddr (ADDR_W'(code)),
        .rdata (ram_rdata)
    );

    // differences in 1/16 pixel
    assign col_sum = $signed({2'b00, col_cur}) + SUM_W'(off_reg);
    assign dx_next = $signed({col_sum, 4'b0000}) - $signed({2'b00, cx_reg});
    assign dy_next = $signed({2'b00, row_cur, 4'b0000}) - $signed({2'b00, cy_reg});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            e1_reg <= 1'b0;
            e2_reg <= 1'b0;
            e3_reg <= 1'b0;
        end else begin
            e1_reg <= pixel_acc && on_grid;
            e2_reg <= e1_reg;
            e3_reg <= e2_reg;
        end
        dx1_reg  <= dx_next;
        dy1_reg  <= dy_next;
        oob1_reg <= oob;
        col1_reg <= col_cur;
        row1_reg <= row_cur;
        z2_reg   <= z_s1;
        col2_reg <= col1_reg;
        row2_reg <= row1_reg;
        z3_reg   <= z2_reg;
        col3_reg <= col2_reg;
        row3_reg <= row2_reg;
    end

    assign z_s1 = oob1_reg ? '0 : ram_rdata;

    dfpc_proj u_proj_x (
        .aclk   (aclk),
        .d      (dx1_reg),
        .z      (z_s1),
        .inv    (ifx_reg),
        .result (x_pt)
    );

    dfpc_proj u_proj_y (
        .aclk   (aclk),
        .d      (dy1_reg),
        .z      (z_s1),
        .inv    (ify_reg),
        .result (y_pt)
    );

    dfpc_out_fifo #(
        .WIDTH (dfpc_pkg::M_TDATA_W),
        .DEPTH (dfpc_pkg::OUT_DEPTH)
    ) u_out_q (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (e3_reg),
        .push_data ({row3_reg, col3_reg, z3_reg, y_pt, x_pt}),
        .pop       (m_tready),
        .head      (m_tdata),
        .count     (q_count)
    );

    assign m_tvalid = q_count != '0;

    ap_queue_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        occ <= OCC_W'(dfpc_pkg::OUT_DEPTH))
        else $error("result queue overcommitted");

    ap_phase_range: assert property (@(posedge aclk) disable iff (!aresetn)
        !hold_in |-> (cph_reg < step_eff) && (rph_reg < step_eff))
        else $error("raster phase not below mesh step");

    ap_frame_start: assert property (@(posedge aclk) disable iff (!aresetn)
        (pixel_acc && first) |=> e1_reg)
        else $error("first pixel of frame did not enter the pipeline");

    ap_out_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(e3_reg))
        else $error("output beat without a point from the pipeline");

endmodule
`default_nettype wire
